[src/sorted_priority_queue_top_macros.svh]
// Assertion macros used by the priority queue top RTL
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

[src/spq_pkg.sv]
// Types and codes for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  // broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
  } spq_ctrl_t;

endpackage

[src/sorted_priority_queue_top.sv]
// Sorted priority queue, largest priority first
// Usage:
//   Input channel in_*: in_op selects insert (pair taken from in_item_in and
//   in_priority_in) or delete of the head pair. Every accepted item yields
//   exactly one result on out_*: a status (ok, overflow, empty), the removed
//   pair on a good delete (zero otherwise) and the fill level afterwards.
//   The result is registered at the edge that accepts the item. While
//   in_stall is low, throughput is one item per cycle; every cell of the row
//   compares its priority with the newcomer in parallel and shifts in the
//   same cycle, so the cost of an item does not depend on the fill level.
//   If out_stall holds the result, in_stall rises and input waits; the
//   pending result stays unchanged until taken.
//   Reset empties the queue (count cleared) and drops any pending result;
//   no clearing pass is needed, cells beyond the count are never read.
//   Equal priorities leave in arrival order.
`timescale 1ns / 1ps
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    in_op,
  input  data_t   in_item_in,
  input  data_t   in_priority_in,
  output logic    out_valid,
  input  logic    out_stall,
  output status_t out_status,
  output data_t   out_item_out,
  output data_t   out_priority_out,
  output fill_t   out_fill_level
);

`include "sorted_priority_queue_top_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  data_t            out_item_r, out_item_nxt;
  data_t            out_prio_r, out_prio_nxt;
  fill_t            out_fill_r, out_fill_nxt;

  logic             in_acc;
  logic             full;
  logic             empty;
  spq_ctrl_t        ctrl;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  data_t            cell_item [DEPTH];
  data_t            cell_prio [DEPTH];
  logic             cell_keep [DEPTH];
  logic [DEPTH-1:0] occ;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);

  assign ctrl.ins = in_acc && (in_op == OP_INSERT) && !full;
  assign ctrl.del = in_acc && (in_op == OP_DELETE) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      data_t l_item, l_prio, r_item, r_prio;
      logic  l_keep;

      assign occ[i] = (cnt_r > CNT_W'(i));

      if (i == 0) begin : g_head
        assign l_item = in_item_in;
        assign l_prio = in_priority_in;
        assign l_keep = 1'b1;
      end else begin : g_body
        assign l_item = cell_item[i-1];
        assign l_prio = cell_prio[i-1];
        assign l_keep = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_item = cell_item[i];
        assign r_prio = cell_prio[i];
      end else begin : g_mid
        assign r_item = cell_item[i+1];
        assign r_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ[i]),
        .new_item   (in_item_in),
        .new_prio   (in_priority_in),
        .left_item  (l_item),
        .left_prio  (l_prio),
        .left_keep  (l_keep),
        .right_item (r_item),
        .right_prio (r_prio),
        .item       (cell_item[i]),
        .prio       (cell_prio[i]),
        .keep       (cell_keep[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, cnt_nxt};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_prio_nxt   = out_prio_r;
    out_fill_nxt   = out_fill_r;
    if (in_acc) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_item_nxt   = '0;
      out_prio_nxt   = '0;
      out_fill_nxt   = fill_ext[FILL_W-1:0];
      if (in_op == OP_INSERT) begin
        if (full) begin
          out_status_nxt = ST_OVERFLOW;
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_item_nxt = cell_item[0];
          out_prio_nxt = cell_prio[0];
        end
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_prio_r   <= out_prio_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_item_out     = out_item_r;
  assign out_priority_out = out_prio_r;
  assign out_fill_level   = out_fill_r;

  `SPQ_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_del_empty, clk, rst_n, in_acc && (in_op == OP_DELETE) && empty, out_status_r == ST_EMPTY && out_fill_r == '0 && cnt_r == '0)
  `SPQ_ASSERT_NEXT(a_del_count, clk, rst_n, ctrl.del, cnt_r == $past(cnt_r) - CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_ovf_hold, clk, rst_n, in_acc && (in_op == OP_INSERT) && full, out_status_r == ST_OVERFLOW && cnt_r == CNT_W'(DEPTH))

  generate
    if (DEPTH > 1) begin : g_order_chk
      `SPQ_ASSERT_IMPL(a_head_order, clk, rst_n, cnt_r >= CNT_W'(2), !(cell_prio[0] < cell_prio[1]))
    end
  endgenerate

endmodule

[src/spq_cell.sv]
// One slot of the sorted shift-register row
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  spq_ctrl_t ctrl,
  input  logic      occ,
  input  data_t     new_item,
  input  data_t     new_prio,
  input  data_t     left_item,
  input  data_t     left_prio,
  input  logic      left_keep,
  input  data_t     right_item,
  input  data_t     right_prio,
  output data_t     item,
  output data_t     prio,
  output logic      keep
);

  data_t item_r;
  data_t prio_r;

  // held entry stays put if it ranks at or above the newcomer (ties keep arrival order)
  assign keep = occ && !(prio_r < new_prio);
  assign item = item_r;
  assign prio = prio_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          item_r <= new_item;
          prio_r <= new_prio;
        end else begin
          item_r <= left_item;
          prio_r <= left_prio;
        end
      end
    end else if (ctrl.del) begin
      item_r <= right_item;
      prio_r <= right_prio;
    end
  end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the sorted priority queue: random traffic against a shadow queue
`timescale 1ns / 1ps
module tb_top;
  import spq_pkg::*;

  localparam int PQ_DEPTH   = 16;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic  op;
    data_t item;
    data_t prio;
    bit    hold;   // wait for every outstanding result before presenting
  } pq_req_t;

  typedef struct packed {
    status_t status;
    data_t   item;
    data_t   prio;
    fill_t   fill;
  } pq_result_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  logic    in_op = OP_INSERT;
  data_t   in_item_in = '0;
  data_t   in_priority_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  status_t out_status;
  data_t   out_item_out;
  data_t   out_priority_out;
  fill_t   out_fill_level;

  sorted_priority_queue_top #(
    .DEPTH(PQ_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_item_in      (in_item_in),
    .in_priority_in  (in_priority_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_item_out    (out_item_out),
    .out_priority_out(out_priority_out),
    .out_fill_level  (out_fill_level)
  );

  always #5 clk = ~clk;

  // shadow of the queue contents, head at index 0
  data_t shadow_item [PQ_DEPTH];
  data_t shadow_prio [PQ_DEPTH];
  int    shadow_count = 0;

  pq_req_t    pending_ops[$];
  pq_result_t due_results[$];
  pq_req_t    op_now;

  bit          in_taken = 1'b0;
  int          idle_cycles = 0;
  int          err_cnt = 0;
  int          n_built = 0;
  int          n_taken = 0;
  int          n_checked = 0;
  int          n_ins_ok = 0;
  int          n_del_ok = 0;
  int          n_overflow = 0;
  int          n_empty = 0;
  int          max_fill = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int unsigned rx_cycle = 0;

  function automatic pq_result_t pq_apply(input logic op, input data_t item, input data_t prio);
    pq_result_t r;
    int         pos;
    r = '{status: ST_OK, item: '0, prio: '0, fill: '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= PQ_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // new pair goes behind every pair of equal priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_item[i] = shadow_item[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_item[pos] = item;
        shadow_prio[pos] = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.item = shadow_item[0];
        r.prio = shadow_prio[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_item[i-1] = shadow_item[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    r.fill = fill_t'(shadow_count);
    return r;
  endfunction

  task automatic queue_op(input logic op, input data_t item, input data_t prio, input bit hold);
    pq_req_t req;
    req.op   = op;
    req.item = item;
    req.prio = prio;
    req.hold = hold;
    pending_ops.push_back(req);
    n_built++;
  endtask

  // often a narrow band so ties are common, sometimes the extremes, else any value
  function automatic data_t pick_prio();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return data_t'($signed($urandom_range(0, 6)) - 3);
      4:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    return data_t'($urandom);
    endcase
  endfunction

  // sender: bursts of items separated by gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].hold && due_results.size() != 0)) begin
        op_now = pending_ops.pop_front();
        in_valid       <= 1'b1;
        in_op          <= op_now.op;
        in_item_in     <= op_now.item;
        in_priority_in <= op_now.prio;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 24);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(8, 20);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern cycles through calm, light, heavy and periodic
  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    case ((rx_cycle / 64) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((rx_cycle % 11) < 4);
    endcase
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    pq_result_t exp_res;
    pq_result_t got_res;
    bit         out_taken;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (out_taken) begin
        got_res = '{status: out_status, item: out_item_out, prio: out_priority_out,
                    fill: out_fill_level};
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d item %0d", out_status,
                 out_item_out);
          err_cnt++;
        end else begin
          exp_res = due_results.pop_front();
          n_checked++;
          if (got_res.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got_res.status);
            err_cnt++;
          end
          if (got_res.item !== exp_res.item) begin
            $error("item_out: expected %0d, got %0d", exp_res.item, got_res.item);
            err_cnt++;
          end
          if (got_res.prio !== exp_res.prio) begin
            $error("priority_out: expected %0d, got %0d", exp_res.prio, got_res.prio);
            err_cnt++;
          end
          if (got_res.fill !== exp_res.fill) begin
            $error("fill_level: expected %0d, got %0d", exp_res.fill, got_res.fill);
            err_cnt++;
          end
        end
      end
      if (in_taken) begin
        exp_res = pq_apply(in_op, in_item_in, in_priority_in);
        due_results.push_back(exp_res);
        n_taken++;
        case (exp_res.status)
          ST_OVERFLOW: n_overflow++;
          ST_EMPTY:    n_empty++;
          default:     if (in_op == OP_INSERT) n_ins_ok++; else n_del_ok++;
        endcase
        if (shadow_count > max_fill) max_fill = shadow_count;
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int seg_len;
    int ins_pct;
    int seg_no;

    // directed: empty delete, fill with extremes and ties, overflow, partial drain
    queue_op(OP_DELETE, 32'd0, 32'd0, 1'b0);
    queue_op(OP_INSERT, 32'h7fff_ffff, 32'd0, 1'b0);
    queue_op(OP_INSERT, 32'h8000_0000, 32'd0, 1'b0);
    queue_op(OP_INSERT, 32'd1, 32'h7fff_ffff, 1'b0);
    queue_op(OP_INSERT, 32'd2, 32'h8000_0000, 1'b0);
    queue_op(OP_INSERT, 32'd3, 32'd0, 1'b0);
    queue_op(OP_INSERT, 32'd4, -32'sd1, 1'b0);
    queue_op(OP_INSERT, 32'd5, 32'd1, 1'b0);
    queue_op(OP_INSERT, 32'd6, 32'h7fff_ffff, 1'b0);
    queue_op(OP_INSERT, 32'd7, 32'h8000_0000, 1'b0);
    queue_op(OP_INSERT, 32'hffff_ffff, 32'd5, 1'b0);
    queue_op(OP_INSERT, 32'd0, -32'sd5, 1'b0);
    queue_op(OP_INSERT, 32'haaaa_aaaa, 32'd1, 1'b0);
    queue_op(OP_INSERT, 32'h5555_5555, 32'd0, 1'b0);
    queue_op(OP_INSERT, 32'd8, -32'sd1, 1'b0);
    queue_op(OP_INSERT, 32'd9, 32'd100, 1'b0);
    queue_op(OP_INSERT, 32'd10, 32'h8000_0001, 1'b0);
    queue_op(OP_INSERT, 32'd12345, 32'h7fff_ffff, 1'b0);
    repeat (6) queue_op(OP_DELETE, $urandom, $urandom, 1'b0);

    // random: segments leaning towards filling, draining or balanced
    seg_no = 0;
    while (n_built < 900) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 25;
        default: ins_pct = 50;
      endcase
      for (int k = 0; k < seg_len; k++) begin
        queue_op(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE,
                 ($urandom_range(0, 15) == 0) ? data_t'(0) : data_t'($urandom),
                 pick_prio(), (k == 0) && (seg_no % 5 == 0));
      end
      seg_no++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken != n_built || due_results.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d items: %0d inserts, %0d deletes, %0d overflows, %0d empty deletes",
             n_taken, n_ins_ok, n_del_ok, n_overflow, n_empty);
    $display("%0d results checked, deepest fill %0d of %0d, %0d mismatches",
             n_checked, max_fill, PQ_DEPTH, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
verif/tb_top.sv
